FILE: design/day_count_to_ethiopian_date_unit_macros.svh
// Assertion macros shared by the date conversion RTL.
`ifndef DAY_COUNT_TO_ETHIOPIAN_DATE_UNIT_MACROS_SVH
`define DAY_COUNT_TO_ETHIOPIAN_DATE_UNIT_MACROS_SVH

// Same-cycle implication, muted during reset.
`define DCE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dce assertion failed");

// Next-cycle implication, muted during reset.
`define DCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dce assertion failed");

`endif

FILE: design/dce_pkg.sv
// Types and constants for the day count to Ethiopian date converter.
`timescale 1ns / 1ps
`default_nettype none
package dce_pkg;

   localparam int DAY_BITS   = 20;
   localparam int REM_BITS   = 21;
   localparam int QUO_BITS   = 10;
   localparam int WK_BITS    = 13;
   localparam int DATA_BITS  = 24;

   localparam logic [REM_BITS-1:0] EPOCH_SHIFT     = 21'd534107;
   localparam logic [REM_BITS-1:0] CYCLE_DAYS      = 21'd1461;
   localparam logic [REM_BITS-1:0] COMMON_YEAR_LEN = 21'd365;
   localparam logic [REM_BITS-1:0] MONTH_DAYS      = 21'd30;
   localparam logic [REM_BITS-1:0] WEEK_DAYS       = 21'd7;
   localparam logic [11:0]         FIRST_YEAR      = 12'd500;
   localparam logic [WK_BITS-1:0]  WEEK_OFFSET     = 13'd3;

   // operands into the shared compare/subtract unit
   typedef struct packed {
      logic [REM_BITS-1:0] minuend;
      logic [REM_BITS-1:0] divisor;
   } unit_req_type;

   // result of the shared unit
   typedef struct packed {
      logic                ge;
      logic [REM_BITS-1:0] diff;
   } unit_rsp_type;

endpackage
`default_nettype wire

FILE: design/dce_cmp_sub.sv
// Shared compare and subtract unit for the restoring reduction steps.
`timescale 1ns / 1ps
`default_nettype none
module dce_cmp_sub (
   input  dce_pkg::unit_req_type req,
   output dce_pkg::unit_rsp_type rsp
);
   import dce_pkg::*;

   logic [REM_BITS:0] wide_diff;

   // one wide subtract; the borrow tells whether the divisor fits
   always_comb begin
      wide_diff = {1'b0, req.minuend} - {1'b0, req.divisor};
      rsp.ge    = ~wide_diff[REM_BITS];
      rsp.diff  = wide_diff[REM_BITS-1:0];
   end

endmodule
`default_nettype wire

FILE: design/day_count_to_ethiopian_date_unit.sv
// Top level: sequencer that turns a signed day count into an Ethiopian date.
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tdata day_number, tuser missing
//  rsp     | out | rsp_tvalid/rsp_tready  | tdata year/month/day/weekday, tuser valid
//
// A present item passes, from accept to result, through 10 steps of
// four-year cycles, 1 weekday setup, 10 weekday steps, 1 to 4 year steps,
// 4 month steps and a finish step, all through the one compare/subtract unit.
// A missing item goes straight to the finish step. The next word is taken once
// the unit is idle, even while a result still waits in the output register.
// Reset is synchronous; a stalled result holds the sequencer in its finish step.
`timescale 1ns / 1ps
`default_nettype none
`include "day_count_to_ethiopian_date_unit_macros.svh"
module day_count_to_ethiopian_date_unit (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_tvalid,
   output logic                          req_tready,
   // [19:0] day_number, [23:20] zero
   input  wire  [dce_pkg::DATA_BITS-1:0] req_tdata,
   // [0] missing
   input  wire                           req_tuser,
   output logic                          rsp_tvalid,
   input  wire                           rsp_tready,
   // [11:0] cal_year, [15:12] cal_month, [20:16] cal_day, [23:21] week_day
   output logic [dce_pkg::DATA_BITS-1:0] rsp_tdata,
   // [0] valid_res
   output logic                          rsp_tuser
);
   import dce_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CYC   = 3'd1;
   localparam logic [2:0] ST_WLOAD = 3'd2;
   localparam logic [2:0] ST_WEEK  = 3'd3;
   localparam logic [2:0] ST_YEAR  = 3'd4;
   localparam logic [2:0] ST_MON   = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   localparam logic [3:0] CYC_TOP  = 4'd9;
   localparam logic [3:0] WEEK_TOP = 4'd9;
   localparam logic [3:0] MON_TOP  = 4'd3;

   logic [2:0]           state_ff, state_in;
   logic [3:0]           step_ff, step_in;
   logic [REM_BITS-1:0]  rem_ff, rem_in;
   logic [QUO_BITS-1:0]  quo_ff, quo_in;
   logic [WK_BITS-1:0]   wk_ff, wk_in;
   logic [1:0]           k_ff, k_in;
   logic [3:0]           mon_ff, mon_in;
   logic                 miss_ff, miss_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                 rsp_user_ff, rsp_user_in;

   unit_req_type         unit_req;
   unit_rsp_type         unit_rsp;
   logic [DAY_BITS+1:0]  shifted_day;
   logic                 out_free;

   dce_cmp_sub u_cmp_sub (
      .req (unit_req),
      .rsp (unit_rsp)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   // day count moved so that Meskerem 1 of year 500 is day zero
   assign shifted_day = $signed({{2{req_tdata[DAY_BITS-1]}}, req_tdata[DAY_BITS-1:0]})
                        + $signed({1'b0, EPOCH_SHIFT});

   // operand select for the shared unit
   always_comb begin
      unit_req.minuend = rem_ff;
      unit_req.divisor = COMMON_YEAR_LEN;
      case (state_ff)
         ST_CYC:  unit_req.divisor = CYCLE_DAYS << step_ff;
         ST_WEEK: begin
            unit_req.minuend = REM_BITS'(wk_ff);
            unit_req.divisor = WEEK_DAYS << step_ff;
         end
         ST_MON:  unit_req.divisor = MONTH_DAYS << step_ff;
         default: unit_req.divisor = COMMON_YEAR_LEN;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      wk_in        = wk_ff;
      k_in         = k_ff;
      mon_in       = mon_ff;
      miss_in      = miss_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               miss_in = req_tuser;
               rem_in  = shifted_day[REM_BITS-1:0];
               quo_in  = '0;
               step_in = CYC_TOP;
               state_in = req_tuser ? ST_FIN : ST_CYC;
            end
         end
         ST_CYC: begin
            if (unit_rsp.ge) begin
               rem_in = unit_rsp.diff;
               quo_in[step_ff] = 1'b1;
            end
            if (step_ff == 4'd0) state_in = ST_WLOAD;
            else step_in = step_ff - 4'd1;
         end
         ST_WLOAD: begin
            // u mod 7 follows from 1461 mod 7 = 5
            wk_in = WK_BITS'({quo_ff, 2'b00}) + WK_BITS'(quo_ff)
                    + WK_BITS'(rem_ff[10:0]) + WEEK_OFFSET;
            step_in  = WEEK_TOP;
            state_in = ST_WEEK;
         end
         ST_WEEK: begin
            if (unit_rsp.ge) wk_in = unit_rsp.diff[WK_BITS-1:0];
            if (step_ff == 4'd0) begin
               k_in     = '0;
               state_in = ST_YEAR;
            end else begin
               step_in = step_ff - 4'd1;
            end
         end
         ST_YEAR: begin
            // the last day of a cycle stays in the leap year
            if (unit_rsp.ge && (k_ff != 2'd3)) begin
               rem_in = unit_rsp.diff;
               k_in   = k_ff + 2'd1;
            end else begin
               mon_in   = '0;
               step_in  = MON_TOP;
               state_in = ST_MON;
            end
         end
         ST_MON: begin
            if (unit_rsp.ge) begin
               rem_in = unit_rsp.diff;
               mon_in[step_ff[1:0]] = 1'b1;
            end
            if (step_ff == 4'd0) state_in = ST_FIN;
            else step_in = step_ff - 4'd1;
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (miss_ff) begin
                  rsp_data_in = '0;
                  rsp_user_in = 1'b0;
               end else begin
                  rsp_data_in[11:0]  = FIRST_YEAR + {quo_ff, 2'b00} + 12'(k_ff);
                  rsp_data_in[15:12] = mon_ff + 4'd1;
                  rsp_data_in[20:16] = rem_ff[4:0] + 5'd1;
                  rsp_data_in[23:21] = wk_ff[2:0] + 3'd1;
                  rsp_user_in        = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      wk_ff       <= wk_in;
      k_ff        <= k_in;
      mon_ff      <= mon_in;
      miss_ff     <= miss_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   `DCE_ASSERT_NOW(a_year_rem, clock, reset, state_ff == ST_YEAR, rem_ff < CYCLE_DAYS)
   `DCE_ASSERT_NOW(a_mon_rem, clock, reset, state_ff == ST_MON, rem_ff < (COMMON_YEAR_LEN + 21'd1))
   `DCE_ASSERT_NOW(a_week_rem, clock, reset, state_ff == ST_WEEK, wk_ff < 13'd7168)
   `DCE_ASSERT_NOW(a_month_range, clock, reset, rsp_tvalid && rsp_tuser,
      (rsp_tdata[15:12] != 4'd0) && (rsp_tdata[15:12] <= 4'd13))
   `DCE_ASSERT_NEXT(a_fin_done, clock, reset, state_ff == ST_FIN && out_free,
      rsp_tvalid && (state_ff == ST_IDLE))

endmodule
`default_nettype wire
